@@ design/tgp_pkg.sv @@
// tgp_pkg: shared types, widths, register codes and helpers for the threshold group packer
// no dependencies; used by every design file of the packer
`default_nettype none

package tgp_pkg;

    // default parameter values of the top level
    localparam int VERTEX_BITS_DEF = 20;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int SUM_BITS_DEF    = 32;

    // fixed field widths of the channels
    localparam int ID_W        = 20;
    localparam int WEIGHT_W    = 16;
    localparam int KIND_W      = 8;
    localparam int CHILD_W     = 16;
    localparam int TOTAL_W     = 32;
    localparam int LIMIT_W     = 32;
    localparam int SIZE_W      = 21;
    localparam int DEGREE_W    = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = '1;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(1 << 20);
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = '1;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEMORY_LIMIT = 3'd0,
        CFG_WORK_LIMIT   = 3'd1,
        CFG_COMM_LIMIT   = 3'd2,
        CFG_SIZE_LIMIT   = 3'd3,
        CFG_DEGREE_LIMIT = 3'd4,
        CFG_SOURCE_ONLY  = 3'd5
    } cfg_index_t;

    // configuration seen by the packing unit
    typedef struct packed {
        logic [LIMIT_W-1:0]  memory_limit;
        logic [LIMIT_W-1:0]  work_limit;
        logic [LIMIT_W-1:0]  comm_limit;
        logic [SIZE_W-1:0]   size_limit;
        logic [DEGREE_W-1:0] degree_limit;
        logic                source_only_memory;
    } cfg_t;

    // one vertex request
    typedef struct packed {
        logic [ID_W-1:0]     vertex_id;
        logic [WEIGHT_W-1:0] mem_weight;
        logic [WEIGHT_W-1:0] work_weight;
        logic [WEIGHT_W-1:0] comm_weight;
        logic                is_source;
        logic [KIND_W-1:0]   node_kind;
        logic [CHILD_W-1:0]  child_count;
        logic                last_vertex;
    } vertex_t;

    // one result request
    typedef struct packed {
        logic [ID_W-1:0]    out_vertex;
        logic [ID_W-1:0]    group_index;
        logic               closed_valid;
        logic [TOTAL_W-1:0] closed_memory;
        logic [TOTAL_W-1:0] closed_work;
        logic [TOTAL_W-1:0] closed_comm;
        logic               final_valid;
        logic [TOTAL_W-1:0] final_memory;
        logic [TOTAL_W-1:0] final_work;
        logic [TOTAL_W-1:0] final_comm;
    } group_t;

    // saturate a running sum to the reported total width
    function automatic logic [TOTAL_W-1:0] clamp_total(input logic [63:0] v);
        logic [TOTAL_W-1:0] r;
        r = (v[63:TOTAL_W] != '0) ? '1 : v[TOTAL_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/tgp_vertex_if.sv @@
// tgp_vertex_if: valid/ready channel carrying one vertex request
// depends on tgp_pkg for field widths
`default_nettype none

interface tgp_vertex_if;
    logic                         valid;
    logic                         ready;
    logic [tgp_pkg::ID_W-1:0]     vertex_id;
    logic [tgp_pkg::WEIGHT_W-1:0] mem_weight;
    logic [tgp_pkg::WEIGHT_W-1:0] work_weight;
    logic [tgp_pkg::WEIGHT_W-1:0] comm_weight;
    logic                         is_source;
    logic [tgp_pkg::KIND_W-1:0]   node_kind;
    logic [tgp_pkg::CHILD_W-1:0]  child_count;
    logic                         last_vertex;

    modport source (
        output valid, vertex_id, mem_weight, work_weight, comm_weight,
               is_source, node_kind, child_count, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_id, mem_weight, work_weight, comm_weight,
               is_source, node_kind, child_count, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

@@ design/tgp_group_if.sv @@
// tgp_group_if: valid/ready channel carrying one group result request
// depends on tgp_pkg for field widths
`default_nettype none

interface tgp_group_if;
    logic                        valid;
    logic                        ready;
    logic [tgp_pkg::ID_W-1:0]    out_vertex;
    logic [tgp_pkg::ID_W-1:0]    group_index;
    logic                        closed_valid;
    logic [tgp_pkg::TOTAL_W-1:0] closed_memory;
    logic [tgp_pkg::TOTAL_W-1:0] closed_work;
    logic [tgp_pkg::TOTAL_W-1:0] closed_comm;
    logic                        final_valid;
    logic [tgp_pkg::TOTAL_W-1:0] final_memory;
    logic [tgp_pkg::TOTAL_W-1:0] final_work;
    logic [tgp_pkg::TOTAL_W-1:0] final_comm;

    modport source (
        output valid, out_vertex, group_index, closed_valid, closed_memory,
               closed_work, closed_comm, final_valid, final_memory,
               final_work, final_comm,
        input  ready
    );
    modport sink (
        input  valid, out_vertex, group_index, closed_valid, closed_memory,
               closed_work, closed_comm, final_valid, final_memory,
               final_work, final_comm,
        output ready
    );
endinterface

`default_nettype wire

@@ design/tgp_cfg_regs.sv @@
// tgp_cfg_regs: write-only configuration register file of the packer
// depends on tgp_pkg for register codes, widths and the cfg_t struct
`default_nettype none

module tgp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tgp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tgp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tgp_pkg::cfg_t                        cfg
);
    import tgp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MEMORY_LIMIT: cfg_next.memory_limit = cfg_data[LIMIT_W-1:0];
                CFG_WORK_LIMIT:   cfg_next.work_limit   = cfg_data[LIMIT_W-1:0];
                CFG_COMM_LIMIT:   cfg_next.comm_limit   = cfg_data[LIMIT_W-1:0];
                CFG_SIZE_LIMIT:   cfg_next.size_limit   = cfg_data[SIZE_W-1:0];
                CFG_DEGREE_LIMIT: cfg_next.degree_limit = cfg_data[DEGREE_W-1:0];
                CFG_SOURCE_ONLY:  cfg_next.source_only_memory = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.memory_limit       <= LIMIT_RESET;
            cfg_reg.work_limit         <= LIMIT_RESET;
            cfg_reg.comm_limit         <= LIMIT_RESET;
            cfg_reg.size_limit         <= SIZE_RESET;
            cfg_reg.degree_limit       <= DEGREE_RESET;
            cfg_reg.source_only_memory <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/tgp_in_stage.sv @@
// tgp_in_stage: input register of the packer, takes one vertex request per cycle unless its full slot is not drained
// depends on tgp_pkg and tgp_vertex_if
`default_nettype none

module tgp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tgp_vertex_if.sink      vertices,
    input  wire logic       take,
    output logic            stage_valid,
    output tgp_pkg::vertex_t stage_vertex
);
    import tgp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    vertex_t vertex_reg;
    logic    accept;

    // free slot or slot drains this cycle
    assign vertices.ready = !valid_reg || take;
    assign accept         = vertices.valid && vertices.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vertex_reg.vertex_id   <= vertices.vertex_id;
            vertex_reg.mem_weight  <= vertices.mem_weight;
            vertex_reg.work_weight <= vertices.work_weight;
            vertex_reg.comm_weight <= vertices.comm_weight;
            vertex_reg.is_source   <= vertices.is_source;
            vertex_reg.node_kind   <= vertices.node_kind;
            vertex_reg.child_count <= vertices.child_count;
            vertex_reg.last_vertex <= vertices.last_vertex;
        end
    end

    assign stage_valid  = valid_reg;
    assign stage_vertex = vertex_reg;

endmodule

`default_nettype wire

@@ design/tgp_pack_unit.sv @@
// tgp_pack_unit: group decision, running sums and result register of the packer
// depends on tgp_pkg and tgp_group_if
`default_nettype none

module tgp_pack_unit #(
    parameter int VERTEX_BITS = tgp_pkg::VERTEX_BITS_DEF,
    parameter int WEIGHT_BITS = tgp_pkg::WEIGHT_BITS_DEF,
    parameter int SUM_BITS    = tgp_pkg::SUM_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tgp_pkg::cfg_t    cfg,
    input  wire logic             stage_valid,
    input  wire tgp_pkg::vertex_t stage_vertex,
    output logic                  take,
    tgp_group_if.source           groups
);
    import tgp_pkg::*;

    // running sum width holds a raw weight that may exceed the saturation bound
    localparam int RW   = (SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS;
    localparam int XW   = ((RW > LIMIT_W) ? RW : LIMIT_W) + 1;
    localparam int CW   = VERTEX_BITS + 1;
    localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam logic [XW-1:0] SUM_MAX = XW'((65'd1 << SUM_BITS) - 65'd1);

    logic [RW-1:0]          sum_mem_reg,  sum_mem_next;
    logic [RW-1:0]          sum_work_reg, sum_work_next;
    logic [RW-1:0]          sum_comm_reg, sum_comm_next;
    logic [CW-1:0]          count_reg,    count_next;
    logic [VERTEX_BITS-1:0] number_reg,   number_next;
    logic [KIND_W-1:0]      kind_reg,     kind_next;
    logic [CHILD_W-1:0]     children_reg;
    logic                   first_reg,    first_next;
    logic                   res_valid_reg, res_valid_next;
    group_t                 res_reg,      res_next;

    logic [WEIGHT_BITS-1:0] mem_w, work_w, comm_w;
    logic [XW-1:0]          mem_x, work_x, comm_x;
    logic                   split;
    logic                   new_group;
    logic [VERTEX_BITS-1:0] vid_v;

    // the result register frees up or drains this cycle
    assign take = stage_valid && (!res_valid_reg || groups.ready);

    // weights at the configured width, memory gated in source-only mode
    always_comb
    begin
        mem_w  = WEIGHT_BITS'(stage_vertex.mem_weight);
        work_w = WEIGHT_BITS'(stage_vertex.work_weight);
        comm_w = WEIGHT_BITS'(stage_vertex.comm_weight);
        if (cfg.source_only_memory && !stage_vertex.is_source)
        begin
            mem_w = '0;
        end
    end

    // exact sums for the limit tests
    assign mem_x  = XW'(sum_mem_reg)  + XW'(mem_w);
    assign work_x = XW'(sum_work_reg) + XW'(work_w);
    assign comm_x = XW'(sum_comm_reg) + XW'(comm_w);

    // split decision
    assign split = !first_reg &&
                   ((mem_x  > XW'(cfg.memory_limit)) ||
                    (work_x > XW'(cfg.work_limit))   ||
                    (comm_x > XW'(cfg.comm_limit))   ||
                    (CMPW'(count_reg) >= CMPW'(cfg.size_limit)) ||
                    (children_reg > cfg.degree_limit) ||
                    (kind_reg != stage_vertex.node_kind));
    assign new_group = first_reg || split;

    // next group state
    always_comb
    begin
        sum_mem_next  = sum_mem_reg;
        sum_work_next = sum_work_reg;
        sum_comm_next = sum_comm_reg;
        count_next    = count_reg;
        number_next   = number_reg;
        kind_next     = kind_reg;
        if (new_group)
        begin
            sum_mem_next  = RW'(mem_w);
            sum_work_next = RW'(work_w);
            sum_comm_next = RW'(comm_w);
            count_next    = CW'(1);
            kind_next     = stage_vertex.node_kind;
            number_next   = first_reg ? '0 : number_reg + VERTEX_BITS'(1);
        end
        else
        begin
            sum_mem_next  = (mem_x  > SUM_MAX) ? RW'(SUM_MAX) : RW'(mem_x);
            sum_work_next = (work_x > SUM_MAX) ? RW'(SUM_MAX) : RW'(work_x);
            sum_comm_next = (comm_x > SUM_MAX) ? RW'(SUM_MAX) : RW'(comm_x);
            if (count_reg != '1)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        first_next = stage_vertex.last_vertex;
    end

    // result fields
    assign vid_v = VERTEX_BITS'(stage_vertex.vertex_id);

    always_comb
    begin
        res_next.out_vertex    = ID_W'(vid_v);
        res_next.group_index   = ID_W'(number_next);
        res_next.closed_valid  = split;
        res_next.closed_memory = split ? clamp_total(64'(sum_mem_reg))  : '0;
        res_next.closed_work   = split ? clamp_total(64'(sum_work_reg)) : '0;
        res_next.closed_comm   = split ? clamp_total(64'(sum_comm_reg)) : '0;
        res_next.final_valid   = stage_vertex.last_vertex;
        res_next.final_memory  = stage_vertex.last_vertex ?
                                 clamp_total(64'(sum_mem_next)) : '0;
        res_next.final_work    = stage_vertex.last_vertex ?
                                 clamp_total(64'(sum_work_next)) : '0;
        res_next.final_comm    = stage_vertex.last_vertex ?
                                 clamp_total(64'(sum_comm_next)) : '0;
    end

    // result valid tracking
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (groups.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // group state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_mem_reg   <= '0;
            sum_work_reg  <= '0;
            sum_comm_reg  <= '0;
            count_reg     <= '0;
            number_reg    <= '0;
            kind_reg      <= '0;
            children_reg  <= '0;
            first_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                sum_mem_reg  <= sum_mem_next;
                sum_work_reg <= sum_work_next;
                sum_comm_reg <= sum_comm_next;
                count_reg    <= count_next;
                number_reg   <= number_next;
                kind_reg     <= kind_next;
                children_reg <= stage_vertex.child_count;
                first_reg    <= first_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign groups.valid         = res_valid_reg;
    assign groups.out_vertex    = res_reg.out_vertex;
    assign groups.group_index   = res_reg.group_index;
    assign groups.closed_valid  = res_reg.closed_valid;
    assign groups.closed_memory = res_reg.closed_memory;
    assign groups.closed_work   = res_reg.closed_work;
    assign groups.closed_comm   = res_reg.closed_comm;
    assign groups.final_valid   = res_reg.final_valid;
    assign groups.final_memory  = res_reg.final_memory;
    assign groups.final_work    = res_reg.final_work;
    assign groups.final_comm    = res_reg.final_comm;

endmodule

`default_nettype wire

@@ design/threshold_group_packer_core.sv @@
// threshold_group_packer_core: top level of the threshold group packer
// an accepted vertex is held in the input register, then its result in the result register
// throughput: one vertex per cycle unless the result channel stalls; the group decision
// between the input register and the result register is combinational
// reset: group state cleared, next vertex opens group 0, registers at defaults
// depends on tgp_pkg, tgp_vertex_if, tgp_group_if, tgp_cfg_regs, tgp_in_stage, tgp_pack_unit
`default_nettype none

module threshold_group_packer_core #(
    parameter int VERTEX_BITS = tgp_pkg::VERTEX_BITS_DEF,
    parameter int WEIGHT_BITS = tgp_pkg::WEIGHT_BITS_DEF,
    parameter int SUM_BITS    = tgp_pkg::SUM_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tgp_vertex_if.sink                           vertices,
    tgp_group_if.source                          groups,
    input  wire logic                            cfg_we,
    input  wire logic [tgp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgp_pkg::*;

    cfg_t    cfg;
    logic    stage_valid;
    vertex_t stage_vertex;
    logic    take;

    // configuration registers
    tgp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    tgp_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertices     (vertices),
        .take         (take),
        .stage_valid  (stage_valid),
        .stage_vertex (stage_vertex)
    );

    // group decision and result register
    tgp_pack_unit #(
        .VERTEX_BITS (VERTEX_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_pack_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stage_valid  (stage_valid),
        .stage_vertex (stage_vertex),
        .take         (take),
        .groups       (groups)
    );

endmodule

`default_nettype wire

@@ design/tgp_checker.sv @@
// tgp_checker: port-level checks on the result channel of the packer, bound to the top level
// depends on tgp_pkg for field widths
`default_nettype none

module tgp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        valid,
    input wire logic                        ready,
    input wire logic [tgp_pkg::ID_W-1:0]    group_index,
    input wire logic                        closed_valid,
    input wire logic [tgp_pkg::TOTAL_W-1:0] closed_memory,
    input wire logic [tgp_pkg::TOTAL_W-1:0] closed_work,
    input wire logic [tgp_pkg::TOTAL_W-1:0] closed_comm,
    input wire logic                        final_valid,
    input wire logic [tgp_pkg::TOTAL_W-1:0] final_memory,
    input wire logic [tgp_pkg::TOTAL_W-1:0] final_work,
    input wire logic [tgp_pkg::TOTAL_W-1:0] final_comm
);
    import tgp_pkg::*;

    // a stalled result keeps its group index
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(group_index))
        else $error("result changed while stalled");

    // no closed totals without a closed group
    a_closed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !closed_valid |->
            closed_memory == '0 && closed_work == '0 && closed_comm == '0)
        else $error("closed totals set without closed group");

    // no final totals without the last vertex
    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !final_valid |->
            final_memory == '0 && final_work == '0 && final_comm == '0)
        else $error("final totals set without last vertex");

    // a result after a final one opens group zero without a closed report
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && final_valid ##1 valid && $past(valid && ready) |->
            group_index == '0 && !closed_valid)
        else $error("ordering did not restart after last vertex");

endmodule

bind threshold_group_packer_core tgp_checker u_tgp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (groups.valid),
    .ready         (groups.ready),
    .group_index   (groups.group_index),
    .closed_valid  (groups.closed_valid),
    .closed_memory (groups.closed_memory),
    .closed_work   (groups.closed_work),
    .closed_comm   (groups.closed_comm),
    .final_valid   (groups.final_valid),
    .final_memory  (groups.final_memory),
    .final_work    (groups.final_work),
    .final_comm    (groups.final_comm)
);

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: checks threshold_group_packer_core by predicting each vertex's group report
// depends on tgp_pkg, tgp_vertex_if, tgp_group_if and the design files of the packer
`default_nettype none

module testbench;
    import tgp_pkg::*;

    localparam int RUN_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_VERTICES = 250;
    localparam logic [63:0] SUM_CEIL = 64'hFFFF_FFFF;
    localparam logic [63:0] MEMBERS_CEIL = (64'd1 << (ID_W + 1)) - 64'd1;

    // group packing predictor with its own copy of registers and group state
    class group_packer_model;
        logic [63:0] lim_memory;
        logic [63:0] lim_work;
        logic [63:0] lim_comm;
        logic [63:0] lim_size;
        logic [63:0] lim_degree;
        bit          source_only;
        logic [63:0] acc_memory;
        logic [63:0] acc_work;
        logic [63:0] acc_comm;
        logic [63:0] members;
        logic [ID_W-1:0]    group_no;
        logic [KIND_W-1:0]  open_kind;
        logic [CHILD_W-1:0] prev_children;
        bit          fresh;
        group_t      expected_groups[$];
        int          mismatch_count;

        function new();
            lim_memory = SUM_CEIL;
            lim_work = SUM_CEIL;
            lim_comm = SUM_CEIL;
            lim_size = 64'd1 << 20;
            lim_degree = 64'd65535;
            source_only = 1'b0;
            acc_memory = '0;
            acc_work = '0;
            acc_comm = '0;
            members = '0;
            group_no = '0;
            open_kind = '0;
            prev_children = '0;
            fresh = 1'b1;
            mismatch_count = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MEMORY_LIMIT: lim_memory = 64'(value);
                CFG_WORK_LIMIT:   lim_work = 64'(value);
                CFG_COMM_LIMIT:   lim_comm = 64'(value);
                CFG_SIZE_LIMIT:   lim_size = 64'(value[SIZE_W-1:0]);
                CFG_DEGREE_LIMIT: lim_degree = 64'(value[DEGREE_W-1:0]);
                CFG_SOURCE_ONLY:  source_only = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_groups.size();
        endfunction

        function logic [TOTAL_W-1:0] to_total(logic [63:0] v);
            return (v > SUM_CEIL) ? '1 : v[TOTAL_W-1:0];
        endfunction

        function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
            return (a + b > SUM_CEIL) ? SUM_CEIL : a + b;
        endfunction

        // accepted vertex: decide its group and queue the expected report
        function void note_vertex(vertex_t v);
            logic [63:0] mem;
            logic [63:0] work;
            logic [63:0] comm;
            bit          split;
            group_t      r;
            mem = 64'(v.mem_weight);
            work = 64'(v.work_weight);
            comm = 64'(v.comm_weight);
            split = 1'b0;
            r = '0;
            if (source_only && !v.is_source)
                mem = '0;
            if (fresh)
            begin
                group_no = '0;
                acc_memory = mem;
                acc_work = work;
                acc_comm = comm;
                members = 64'd1;
                open_kind = v.node_kind;
                fresh = 1'b0;
            end
            else
            begin
                split = (acc_memory + mem > lim_memory) || (acc_work + work > lim_work) ||
                        (members >= lim_size) || (acc_comm + comm > lim_comm) ||
                        (64'(prev_children) > lim_degree) || (open_kind != v.node_kind);
                if (split)
                begin
                    r.closed_memory = to_total(acc_memory);
                    r.closed_work = to_total(acc_work);
                    r.closed_comm = to_total(acc_comm);
                    group_no = group_no + 1'b1;
                    acc_memory = mem;
                    acc_work = work;
                    acc_comm = comm;
                    members = 64'd1;
                    open_kind = v.node_kind;
                end
                else
                begin
                    acc_memory = add_sat(acc_memory, mem);
                    acc_work = add_sat(acc_work, work);
                    acc_comm = add_sat(acc_comm, comm);
                    if (members < MEMBERS_CEIL)
                        members = members + 64'd1;
                end
            end
            prev_children = v.child_count;
            r.out_vertex = v.vertex_id;
            r.group_index = group_no;
            r.closed_valid = split;
            if (v.last_vertex)
            begin
                r.final_valid = 1'b1;
                r.final_memory = to_total(acc_memory);
                r.final_work = to_total(acc_work);
                r.final_comm = to_total(acc_comm);
                fresh = 1'b1;
            end
            expected_groups.insert(expected_groups.size(), r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        // accepted result against the oldest queued report
        task check_group(group_t got);
            group_t want;
            if (expected_groups.size() == 0)
            begin
                report_mismatch($sformatf("result for vertex %h with no request waiting",
                                          got.out_vertex));
                return;
            end
            want = expected_groups.pop_front();
            check_field("out_vertex", 32'(got.out_vertex), 32'(want.out_vertex));
            check_field("group_index", 32'(got.group_index), 32'(want.group_index));
            check_field("closed_valid", 32'(got.closed_valid), 32'(want.closed_valid));
            check_field("closed_memory", got.closed_memory, want.closed_memory);
            check_field("closed_work", got.closed_work, want.closed_work);
            check_field("closed_comm", got.closed_comm, want.closed_comm);
            check_field("final_valid", 32'(got.final_valid), 32'(want.final_valid));
            check_field("final_memory", got.final_memory, want.final_memory);
            check_field("final_work", got.final_work, want.final_work);
            check_field("final_comm", got.final_comm, want.final_comm);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit no_send_gaps;
    bit no_recv_stalls;
    bit hold_req;
    int cycle_count;
    group_packer_model packer = new();

    tgp_vertex_if vertices_bus();
    tgp_group_if  groups_bus();

    threshold_group_packer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertices  (vertices_bus),
        .groups    (groups_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        return WEIGHT_W'($urandom_range(0, 65535) >> $urandom_range(0, 16));
    endfunction

    function automatic vertex_t make_vertex(logic [ID_W-1:0] id, logic [WEIGHT_W-1:0] mem,
                                            logic [WEIGHT_W-1:0] work,
                                            logic [WEIGHT_W-1:0] comm, logic src,
                                            logic [KIND_W-1:0] kind,
                                            logic [CHILD_W-1:0] children, logic last);
        vertex_t v;
        v.vertex_id = id;
        v.mem_weight = mem;
        v.work_weight = work;
        v.comm_weight = comm;
        v.is_source = src;
        v.node_kind = kind;
        v.child_count = children;
        v.last_vertex = last;
        return v;
    endfunction

    // result side: sample at the falling edge, change ready at the rising edge
    initial
    begin
        group_t got;
        int stall_left;
        stall_left = 0;
        groups_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (groups_bus.valid === 1'b1 && groups_bus.ready === 1'b1)
            begin
                got.out_vertex = groups_bus.out_vertex;
                got.group_index = groups_bus.group_index;
                got.closed_valid = groups_bus.closed_valid;
                got.closed_memory = groups_bus.closed_memory;
                got.closed_work = groups_bus.closed_work;
                got.closed_comm = groups_bus.closed_comm;
                got.final_valid = groups_bus.final_valid;
                got.final_memory = groups_bus.final_memory;
                got.final_work = groups_bus.final_work;
                got.final_comm = groups_bus.final_comm;
                packer.check_group(got);
            end
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                groups_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                groups_bus.ready <= 1'b1;
                if (!no_recv_stalls)
                    stall_left = idle_len();
            end
        end
    end

    // offer one vertex request and wait until it is taken
    task automatic send_vertex(vertex_t v);
        int gap;
        gap = no_send_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            vertices_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertices_bus.valid <= 1'b1;
        vertices_bus.vertex_id <= v.vertex_id;
        vertices_bus.mem_weight <= v.mem_weight;
        vertices_bus.work_weight <= v.work_weight;
        vertices_bus.comm_weight <= v.comm_weight;
        vertices_bus.is_source <= v.is_source;
        vertices_bus.node_kind <= v.node_kind;
        vertices_bus.child_count <= v.child_count;
        vertices_bus.last_vertex <= v.last_vertex;
        do
            @(negedge clk);
        while (vertices_bus.ready !== 1'b1);
        @(posedge clk);
        packer.note_vertex(v);
    endtask

    // stop offering and wait for every queued report
    task automatic wait_idle();
        vertices_bus.valid <= 1'b0;
        while (packer.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        packer.set_register(idx, value);
    endtask

    task automatic configure(logic [31:0] mem, logic [31:0] work, logic [31:0] comm,
                             logic [31:0] size, logic [31:0] degree, logic [31:0] src);
        wait_idle();
        write_register(CFG_MEMORY_LIMIT, mem);
        write_register(CFG_WORK_LIMIT, work);
        write_register(CFG_COMM_LIMIT, comm);
        write_register(CFG_SIZE_LIMIT, size);
        write_register(CFG_DEGREE_LIMIT, degree);
        write_register(CFG_SOURCE_ONLY, src);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r == 2)
            return $urandom;
        return $urandom_range(1000, 300000);
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'd1;
        if (r == 2)
            return 32'd1 << 20;
        return $urandom_range(2, 12);
    endfunction

    function automatic logic [31:0] pick_degree();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'd65535;
        return $urandom_range(0, 40000);
    endfunction

    // one setting, then mostly well-formed orderings with some loose vertices
    task automatic random_phase(int phase, int count);
        vertex_t v;
        int sent;
        int len;
        bit paused;
        logic [ID_W-1:0] id;
        logic [KIND_W-1:0] kind;
        sent = 0;
        paused = 1'b0;
        if (phase == 0)
            configure('1, '1, '1, 32'd1 << 20, 32'd65535, 32'd0);
        else if (phase == 1)
            configure('0, '0, '0, 32'd1, 32'd0, 32'd1);
        else
            configure(pick_limit(), pick_limit(), pick_limit(), pick_size(), pick_degree(),
                      32'($urandom_range(0, 1)));
        no_send_gaps = (phase % 3 == 1);
        no_recv_stalls = (phase % 4 == 2);
        if (phase == 2)
            hold_req = 1'b1;
        while (sent < count)
        begin
            // sender waits out every pending report once mid-phase
            if (phase == 3 && !paused && sent >= count / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                v = make_vertex(ID_W'($urandom), WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                WEIGHT_W'($urandom), 1'($urandom), KIND_W'($urandom),
                                CHILD_W'($urandom), 1'($urandom));
                send_vertex(v);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
                id = ID_W'($urandom);
                kind = KIND_W'($urandom);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        kind = KIND_W'($urandom);
                    v = make_vertex(id, rand_weight(), rand_weight(), rand_weight(),
                                    1'($urandom), kind, CHILD_W'(0), k == len - 1);
                    if ($urandom_range(0, 99) < 85)
                        v.child_count = CHILD_W'($urandom_range(0,
                                                 int'(packer.lim_degree)));
                    else
                        v.child_count = CHILD_W'($urandom);
                    send_vertex(v);
                    id = id + 1'b1;
                end
                sent += len;
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MEMORY_LIMIT;
        cfg_data <= '0;
        vertices_bus.valid <= 1'b0;
        vertices_bus.vertex_id <= '0;
        vertices_bus.mem_weight <= '0;
        vertices_bus.work_weight <= '0;
        vertices_bus.comm_weight <= '0;
        vertices_bus.is_source <= 1'b0;
        vertices_bus.node_kind <= '0;
        vertices_bus.child_count <= '0;
        vertices_bus.last_vertex <= 1'b0;
        no_send_gaps = 1'b0;
        no_recv_stalls = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes and a type change
        send_vertex(make_vertex('0, '0, '0, '0, 1'b0, '0, '0, 1'b0));
        send_vertex(make_vertex('1, '1, '1, '1, 1'b1, '1, '1, 1'b0));
        send_vertex(make_vertex(20'd1, '1, '1, '1, 1'b0, '1, '0, 1'b1));

        // tight settings: one split for each reason, source-only memory
        configure(32'd100, 32'd200, 32'd150, 32'd3, 32'd10, 32'd1);
        send_vertex(make_vertex(20'd2, 16'd60, 16'd10, 16'd10, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd3, 16'd60, 16'd10, 16'd10, 1'b0, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd4, 16'd60, 16'd10, 16'd10, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd5, 16'd10, 16'd195, 16'd10, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd6, 16'd0, 16'd0, 16'd145, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd7, 16'd0, 16'd0, 16'd0, 1'b1, 8'd5, 16'd11, 1'b0));
        send_vertex(make_vertex(20'd8, 16'd0, 16'd0, 16'd0, 1'b0, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd9, 16'd0, 16'd0, 16'd0, 1'b0, 8'd5, 16'd10, 1'b0));
        send_vertex(make_vertex(20'd10, 16'd0, 16'd0, 16'd0, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd11, 16'd0, 16'd0, 16'd0, 1'b1, 8'd5, 16'd0, 1'b0));
        send_vertex(make_vertex(20'd12, 16'd1, 16'd1, 16'd1, 1'b1, 8'd6, 16'd0, 1'b1));

        // zero size limit and zero thresholds: every vertex alone
        configure('0, '0, '0, 32'd0, 32'd0, 32'd0);
        send_vertex(make_vertex(20'd13, '0, '0, '0, 1'b1, 8'd0, '0, 1'b0));
        send_vertex(make_vertex(20'd14, '0, '0, '0, 1'b0, 8'd0, '0, 1'b0));
        send_vertex(make_vertex(20'd15, 16'd1, 16'd1, 16'd1, 1'b0, 8'd0, '1, 1'b1));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
            random_phase(phase, PHASE_VERTICES);

        wait_idle();
        repeat (10) @(posedge clk);
        if (packer.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
